// ----- sv/psb_pkg.sv -----
// Shared types and command codes for the preset slot bank.
`timescale 1ns / 1ps

package psb_pkg;

    localparam int VALUE_W    = 16;
    localparam int VALUE_MAX  = 8;
    localparam int SLOT_OUT_W = 4;

    // Command codes carried in the input transfer
    typedef enum logic [2:0] {
        OP_SAVE      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_NEXT      = 3'd2,
        OP_PREV      = 3'd3,
        OP_NEXT_USED = 3'd4,
        OP_PREV_USED = 3'd5,
        OP_SELECT    = 3'd6,
        OP_RANDOM    = 3'd7
    } psb_op_t;

    typedef struct packed {
        psb_op_t                    command;
        logic [SLOT_OUT_W-1:0]      slot_select;
        logic                       coin;
        logic signed [VALUE_W-1:0]  value_0;
        logic signed [VALUE_W-1:0]  value_1;
        logic signed [VALUE_W-1:0]  value_2;
        logic signed [VALUE_W-1:0]  value_3;
        logic signed [VALUE_W-1:0]  value_4;
        logic signed [VALUE_W-1:0]  value_5;
        logic signed [VALUE_W-1:0]  value_6;
        logic signed [VALUE_W-1:0]  value_7;
    } psb_in_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0]      current_slot;
        logic                       slot_in_use;
        logic                       loaded;
        logic signed [VALUE_W-1:0]  out_value_0;
        logic signed [VALUE_W-1:0]  out_value_1;
        logic signed [VALUE_W-1:0]  out_value_2;
        logic signed [VALUE_W-1:0]  out_value_3;
        logic signed [VALUE_W-1:0]  out_value_4;
        logic signed [VALUE_W-1:0]  out_value_5;
        logic signed [VALUE_W-1:0]  out_value_6;
        logic signed [VALUE_W-1:0]  out_value_7;
    } psb_out_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEEK_UP,
        ST_SEEK_DOWN,
        ST_READ,
        ST_FINISH
    } psb_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic save;
        logic ptr_inc;
        logic ptr_dec;
        logic ptr_target;
        logic set_load;
        logic mem_read;
        logic out_load;
    } psb_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        psb_op_t op;
        logic    coin;
        logic    any_used;
        logic    target_differs;
        logic    hit_up;
        logic    hit_down;
        logic    out_free;
    } psb_stat_t;

endpackage

// ----- sv/preset_slot_bank.sv -----
// Top level of the preset slot bank.
`timescale 1ns / 1ps

// Bank of SLOT_COUNT preset slots, each ROW_COUNT signed 16-bit values plus a
// used flag, with a current-slot pointer; one command in, one result out. The
// block takes one command at a time. Save, next, prev and a select that does
// not move go from decode straight to the finish step, which offers the result.
// Load, a select that moves, and a used-slot search with no used slot add a
// registered read of the slot memory. A used-slot search (next used, prev
// used, random) otherwise steps the pointer one slot per cycle, passing over up
// to SLOT_COUNT - 1 unused slots, until a used slot is found, and then reads. A
// result still waiting in the output register holds the next one back until it
// is taken. A new command is taken while the previous result still waits in the
// output register. There is no clearing pass: the used flags reset at once and
// mask unsaved slots to zero.
module preset_slot_bank
    import psb_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int ROW_COUNT  = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  psb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output psb_out_t out_data
);

    psb_ctrl_t ctrl;
    psb_stat_t stat;

    psb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    psb_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .ROW_COUNT  (ROW_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- sv/psb_ctrl.sv -----
// Command sequencer for the preset slot bank.
`timescale 1ns / 1ps

module psb_ctrl
    import psb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  psb_stat_t stat,
    output psb_ctrl_t ctrl
);

    psb_state_t state_reg;
    psb_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.op)
                    OP_SAVE, OP_NEXT, OP_PREV: state_next = ST_FINISH;
                    OP_LOAD:                   state_next = ST_READ;
                    OP_NEXT_USED:
                        state_next = stat.any_used ? ST_SEEK_UP : ST_READ;
                    OP_PREV_USED:
                        state_next = stat.any_used ? ST_SEEK_DOWN : ST_READ;
                    OP_RANDOM:
                    begin
                        if (!stat.any_used)
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = stat.coin ? ST_SEEK_UP : ST_SEEK_DOWN;
                        end
                    end
                    OP_SELECT:
                        state_next = stat.target_differs ? ST_READ : ST_FINISH;
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_SEEK_UP:
            begin
                if (stat.hit_up)
                begin
                    state_next = ST_READ;
                end
            end
            ST_SEEK_DOWN:
            begin
                if (stat.hit_down)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
            end
            ST_DECODE:
            begin
                unique case (stat.op)
                    OP_SAVE: ctrl.save    = 1'b1;
                    OP_NEXT: ctrl.ptr_inc = 1'b1;
                    OP_PREV: ctrl.ptr_dec = 1'b1;
                    OP_LOAD, OP_NEXT_USED, OP_PREV_USED, OP_RANDOM:
                        ctrl.set_load = 1'b1;
                    OP_SELECT:
                    begin
                        ctrl.ptr_target = stat.target_differs;
                        ctrl.set_load   = stat.target_differs;
                    end
                    default: ctrl.set_load = 1'b0;
                endcase
            end
            ST_SEEK_UP:   ctrl.ptr_inc  = 1'b1;
            ST_SEEK_DOWN: ctrl.ptr_dec  = 1'b1;
            ST_READ:      ctrl.mem_read = 1'b1;
            ST_FINISH:    ctrl.out_load = stat.out_free;
            default:      ctrl.out_load = 1'b0;
        endcase
    end

endmodule

// ----- sv/psb_dpath.sv -----
// Slot memory, used flags, pointer and output register of the preset slot bank.
`timescale 1ns / 1ps

module psb_dpath
    import psb_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int ROW_COUNT  = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  psb_in_t   in_data,
    input  psb_ctrl_t ctrl,
    output psb_stat_t stat,
    output logic      out_valid,
    input  logic      out_ready,
    output psb_out_t  out_data
);

    localparam int PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOT_COUNT - 1);

    typedef logic [ROW_COUNT-1:0][VALUE_W-1:0] row_t;

    row_t                  mem [SLOT_COUNT];
    row_t                  rdata_reg;
    psb_in_t               item_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      ptr_next;
    logic [SLOT_COUNT-1:0] used_reg;
    logic                  any_used_reg;
    logic                  load_reg;
    logic                  out_valid_reg;
    psb_out_t              out_data_reg;

    logic [PTR_W-1:0]      ptr_up;
    logic [PTR_W-1:0]      ptr_down;
    logic [PTR_W-1:0]      target;
    logic signed [VALUE_W-1:0] in_vals  [VALUE_MAX];
    logic signed [VALUE_W-1:0] out_vals [VALUE_MAX];
    row_t                  wdata;
    psb_out_t              result;

    // Neighbor slots with wrap, and the clamped select target
    assign ptr_up   = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign ptr_down = (ptr_reg == '0) ? LAST_SLOT : ptr_reg - 1'b1;

    always_comb
    begin
        if (32'(item_reg.slot_select) >= 32'(SLOT_COUNT))
        begin
            target = LAST_SLOT;
        end
        else
        begin
            target = PTR_W'(item_reg.slot_select);
        end
    end

    // Status back to the controller
    assign stat.op             = item_reg.command;
    assign stat.coin           = item_reg.coin;
    assign stat.any_used       = any_used_reg;
    assign stat.target_differs = (target != ptr_reg);
    assign stat.hit_up         = used_reg[ptr_up];
    assign stat.hit_down       = used_reg[ptr_down];
    assign stat.out_free       = !out_valid_reg || out_ready;

    // Input item holding register
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= in_data;
        end
    end

    // Pointer
    always_comb
    begin
        priority if (ctrl.ptr_inc)
        begin
            ptr_next = ptr_up;
        end
        else if (ctrl.ptr_dec)
        begin
            ptr_next = ptr_down;
        end
        else if (ctrl.ptr_target)
        begin
            ptr_next = target;
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    // Control registers: pointer, used flags, load flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            used_reg     <= '0;
            any_used_reg <= 1'b0;
            load_reg     <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (ctrl.save)
            begin
                used_reg[ptr_reg] <= 1'b1;
                any_used_reg      <= 1'b1;
            end
            if (ctrl.capture)
            begin
                load_reg <= 1'b0;
            end
            else if (ctrl.set_load)
            begin
                load_reg <= 1'b1;
            end
        end
    end

    // Row write data from the captured item
    assign in_vals[0] = item_reg.value_0;
    assign in_vals[1] = item_reg.value_1;
    assign in_vals[2] = item_reg.value_2;
    assign in_vals[3] = item_reg.value_3;
    assign in_vals[4] = item_reg.value_4;
    assign in_vals[5] = item_reg.value_5;
    assign in_vals[6] = item_reg.value_6;
    assign in_vals[7] = item_reg.value_7;

    always_comb
    begin
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            wdata[r] = in_vals[r];
        end
    end

    // Slot memory: one row per slot; a slot never saved is masked by its used flag
    always_ff @(posedge clk)
    begin
        if (ctrl.save)
        begin
            mem[ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_read)
        begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    // Result assembly
    always_comb
    begin
        for (int r = 0; r < VALUE_MAX; r++)
        begin
            out_vals[r] = '0;
            if (r < ROW_COUNT && load_reg && used_reg[ptr_reg])
            begin
                out_vals[r] = rdata_reg[r];
            end
        end
        result.current_slot = SLOT_OUT_W'(ptr_reg);
        result.slot_in_use  = used_reg[ptr_reg];
        result.loaded       = load_reg;
        result.out_value_0  = out_vals[0];
        result.out_value_1  = out_vals[1];
        result.out_value_2  = out_vals[2];
        result.out_value_3  = out_vals[3];
        result.out_value_4  = out_vals[4];
        result.out_value_5  = out_vals[5];
        result.out_value_6  = out_vals[6];
        result.out_value_7  = out_vals[7];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/psb_checker.sv -----
// Port-level checks for the preset slot bank, bound to the top level.
`timescale 1ns / 1ps

module psb_checker
    import psb_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input psb_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input psb_out_t out_data
);

    logic no_values;

    assign no_values = (out_data.out_value_0 == '0) && (out_data.out_value_1 == '0)
                    && (out_data.out_value_2 == '0) && (out_data.out_value_3 == '0)
                    && (out_data.out_value_4 == '0) && (out_data.out_value_5 == '0)
                    && (out_data.out_value_6 == '0) && (out_data.out_value_7 == '0);

    // A waiting command stays offered with the same payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("command changed while waiting");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A result that loaded nothing carries zero values
    a_no_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.loaded |-> no_values)
        else $error("values present without a load");

    // Loading an unused slot yields zero values
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.loaded && !out_data.slot_in_use |-> no_values)
        else $error("unused slot loaded nonzero values");

    // One command at a time: no transfer in right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while one is in flight");

endmodule

bind preset_slot_bank psb_checker u_psb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
